/* hw/rtl/ffha_pkg.sv */
// Shared types and codes for the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

  // Width of the index and size fields carried on the ports.
  localparam int FW = 12;

  // Operation codes of an input word.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESIZE  = 2'd2;

  typedef struct packed {
    logic [1:0]    operation;
    logic [FW-1:0] size_words;
    logic [FW-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic [FW-1:0] result_address;
    logic          success;
    logic          copy_needed;
    logic [FW-1:0] copy_source;
    logic [FW-1:0] copy_length;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RUN,
    ST_RSZ,
    ST_REL,
    ST_CUT,
    ST_HEAD,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } st_t;

  // What the current walk is doing.
  typedef enum logic [1:0] {
    MD_ALLOC,
    MD_INPLACE,
    MD_MOVE
  } mode_t;

endpackage

/* hw/rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator: header memory and its walking sequencer.
`timescale 1ns / 1ps

//  channel  direction  handshake          word type
//  in_      input      in_valid/in_stall  ffha_pkg::in_word_t
//  out_     output     out_valid/out_stall ffha_pkg::out_word_t
//
// All header words live in one memory with a registered read. An
// allocate reads one header per block visited, rereads one per free run that
// is too small, and writes one or two headers; release reads and rewrites one
// header, and a resize may walk the headers twice. The header walk dominates.
// After reset a clearing pass writes all HEAP_WORDS words before the first word is
// taken. A stalled result sits in the output register while the next word runs.

module first_fit_heap_allocator #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffha_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ffha_pkg::out_word_t out_word
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int HW = AW + 1;
  localparam int CW = ((AW > 13) ? AW : 13) + 1;
  localparam int FW = ffha_pkg::FW;
  localparam logic [AW-1:0] LAST = AW'(HEAP_WORDS - 1);
  localparam logic [AW:0]   HEAP_LIM = (AW + 1)'(HEAP_WORDS);

  // Header memory.
  logic [HW-1:0] mem [HEAP_WORDS];
  logic [HW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [HW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control and working registers.
  ffha_pkg::st_t      state_r, state_nxt;
  ffha_pkg::mode_t    mode_r, mode_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [AW-1:0]      p_r, p_nxt;
  logic [AW-1:0]      q_r, q_nxt;
  logic [AW-1:0]      nx_r, nx_nxt;
  logic [AW-1:0]      old_p_r, old_p_nxt;
  logic [AW-1:0]      cut_r, cut_nxt;
  logic [AW-1:0]      head_next_r, head_next_nxt;
  logic [12:0]        len_r, len_nxt;
  logic [FW-1:0]      a_r, a_nxt;
  ffha_pkg::out_word_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  ffha_pkg::out_word_t out_word_r, out_word_nxt;

  // Decoding of the header word that was just read.
  logic [AW-1:0] hdr_v;
  logic          hdr_busy;
  logic          v_in_heap;
  logic [AW-1:0] link_p;
  logic [AW-1:0] link_q;
  logic [CW-1:0] cut_w;
  logic [CW-1:0] span_w;
  logic          fits;
  logic [FW-1:0] in_a_m1;
  logic          in_a_ok;

  assign hdr_v     = rd_data_r[HW-1:1];
  assign hdr_busy  = rd_data_r[0];
  assign v_in_heap = {1'b0, hdr_v} < HEAP_LIM;
  assign link_p    = (hdr_v > p_r && v_in_heap) ? hdr_v : '0;
  assign link_q    = (hdr_v > q_r && v_in_heap) ? hdr_v : '0;
  assign cut_w     = CW'(p_r) + CW'(len_r);
  assign span_w    = CW'(q_r) - CW'(p_r);
  assign fits      = span_w >= CW'(len_r);
  assign in_a_m1   = in_word.address - 12'd1;
  assign in_a_ok   = (in_word.address != '0) && ({20'd0, in_a_m1} < 32'(HEAP_WORDS));

  assign in_stall  = (state_r != ffha_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    p_r         <= p_nxt;
    q_r         <= q_nxt;
    nx_r        <= nx_nxt;
    old_p_r     <= old_p_nxt;
    cut_r       <= cut_nxt;
    head_next_r <= head_next_nxt;
    len_r       <= len_nxt;
    a_r         <= a_nxt;
    res_r       <= res_nxt;
    out_word_r  <= out_word_nxt;
  end

  // Next state, memory ports and results.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    clr_nxt       = clr_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    nx_nxt        = nx_r;
    old_p_nxt     = old_p_r;
    cut_nxt       = cut_r;
    head_next_nxt = head_next_r;
    len_nxt       = len_r;
    a_nxt         = a_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;

    case (state_r)
      // Sweep the memory once: word 0 points to the last word, all else is zero.
      ffha_pkg::ST_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        wd = (clr_r == '0) ? {LAST, 1'b0} : '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST) begin
          state_nxt = ffha_pkg::ST_IDLE;
        end
      end

      // Take a word and start its first read, if it needs one.
      ffha_pkg::ST_IDLE: begin
        if (in_valid) begin
          len_nxt   = {1'b0, in_word.size_words} + 13'd1;
          a_nxt     = in_word.address;
          old_p_nxt = AW'(in_a_m1);
          res_nxt   = '0;
          case (in_word.operation)
            ffha_pkg::OP_ALLOC: begin
              mode_nxt  = ffha_pkg::MD_ALLOC;
              p_nxt     = '0;
              rd_addr   = '0;
              state_nxt = ffha_pkg::ST_WALK;
            end
            ffha_pkg::OP_RELEASE: begin
              res_nxt.success = 1'b1;
              if (in_a_ok) begin
                rd_addr   = AW'(in_a_m1);
                state_nxt = ffha_pkg::ST_REL;
              end else begin
                state_nxt = ffha_pkg::ST_DONE;
              end
            end
            ffha_pkg::OP_RESIZE: begin
              if (in_word.address == '0) begin
                mode_nxt  = ffha_pkg::MD_ALLOC;
                p_nxt     = '0;
                rd_addr   = '0;
                state_nxt = ffha_pkg::ST_WALK;
              end else if (in_a_ok) begin
                mode_nxt  = ffha_pkg::MD_INPLACE;
                p_nxt     = AW'(in_a_m1);
                rd_addr   = AW'(in_a_m1);
                state_nxt = ffha_pkg::ST_RSZ;
              end else begin
                state_nxt = ffha_pkg::ST_DONE;
              end
            end
            default: begin
              state_nxt = ffha_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Release: clear the busy bit of the header just read.
      ffha_pkg::ST_REL: begin
        we        = 1'b1;
        wa        = old_p_r;
        wd        = {hdr_v, 1'b0};
        state_nxt = ffha_pkg::ST_DONE;
      end

      // Resize: the block must link forward inside the heap.
      ffha_pkg::ST_RSZ: begin
        if (link_p == '0) begin
          state_nxt = ffha_pkg::ST_DONE;
        end else begin
          nx_nxt    = link_p;
          q_nxt     = link_p;
          rd_addr   = link_p;
          state_nxt = ffha_pkg::ST_RUN;
        end
      end

      // Main walk: skip busy blocks, open a run at a free one.
      ffha_pkg::ST_WALK: begin
        if (link_p == '0) begin
          res_nxt   = '0;
          state_nxt = ffha_pkg::ST_DONE;
        end else if (hdr_busy) begin
          p_nxt   = link_p;
          rd_addr = link_p;
        end else begin
          q_nxt     = link_p;
          rd_addr   = link_p;
          state_nxt = ffha_pkg::ST_RUN;
        end
      end

      // Extend the run over free blocks, then test the span.
      ffha_pkg::ST_RUN: begin
        if (link_q != '0 && !hdr_busy) begin
          q_nxt   = link_q;
          rd_addr = link_q;
        end else if (fits) begin
          res_nxt = '0;
          res_nxt.success = 1'b1;
          case (mode_r)
            ffha_pkg::MD_INPLACE: begin
              res_nxt.result_address = a_r;
            end
            ffha_pkg::MD_MOVE: begin
              res_nxt.result_address = FW'(p_r + AW'(1));
              res_nxt.copy_needed    = 1'b1;
              res_nxt.copy_source    = a_r;
              res_nxt.copy_length    = FW'(nx_r) - a_r;
            end
            default: begin
              res_nxt.result_address = FW'(p_r + AW'(1));
            end
          endcase
          if (cut_w < CW'(q_r)) begin
            cut_nxt   = AW'(cut_w);
            state_nxt = ffha_pkg::ST_CUT;
          end else begin
            head_next_nxt = q_r;
            state_nxt     = ffha_pkg::ST_HEAD;
          end
        end else if (mode_r == ffha_pkg::MD_INPLACE) begin
          mode_nxt  = ffha_pkg::MD_MOVE;
          p_nxt     = '0;
          rd_addr   = '0;
          state_nxt = ffha_pkg::ST_WALK;
        end else begin
          p_nxt     = q_r;
          rd_addr   = q_r;
          state_nxt = ffha_pkg::ST_WALK;
        end
      end

      // Split off the rest of the span as a free block.
      ffha_pkg::ST_CUT: begin
        we            = 1'b1;
        wa            = cut_r;
        wd            = {q_r, 1'b0};
        head_next_nxt = cut_r;
        state_nxt     = ffha_pkg::ST_HEAD;
      end

      // Mark the claimed block busy.
      ffha_pkg::ST_HEAD: begin
        we = 1'b1;
        wa = p_r;
        wd = {head_next_r, 1'b1};
        state_nxt = (mode_r == ffha_pkg::MD_MOVE) ? ffha_pkg::ST_FREE_RD
                                                  : ffha_pkg::ST_DONE;
      end

      // Moved block: reread the old header after the claim writes.
      ffha_pkg::ST_FREE_RD: begin
        rd_addr   = old_p_r;
        state_nxt = ffha_pkg::ST_FREE_WR;
      end

      ffha_pkg::ST_FREE_WR: begin
        we        = 1'b1;
        wa        = old_p_r;
        wd        = {hdr_v, 1'b0};
        state_nxt = ffha_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ffha_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = ffha_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ffha_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // The header walk only moves forward, so every walk ends.
  a_walk_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffha_pkg::ST_WALK && state_nxt == ffha_pkg::ST_WALK) |=> p_r > $past(p_r))
    else $error("header walk did not advance");

  // No header is written while a walk is reading the memory.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffha_pkg::ST_WALK || state_r == ffha_pkg::ST_RUN) |-> !we)
    else $error("memory write during header walk");

  // A copy request only comes with a successful move to a real block.
  a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.copy_needed) |-> (out_word.success && out_word.result_address != '0))
    else $error("copy requested without a granted block");
`endif

endmodule
